// ===== sv/lzs_pkg.sv =====
// ----------------------------------------------------------------------------
// lzs_pkg
// Shared types, constants and helpers for the largest zero square finder.
// ----------------------------------------------------------------------------
package lzs_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_MAX_COLS      = 1024;
    localparam int unsigned DEF_MAX_ROWS      = 1024;
    localparam int unsigned DEF_ELEMENT_WIDTH = 32;

    // Fixed field widths
    localparam int unsigned REG_W     = 11;   // row_count / column_count
    localparam int unsigned SIDE_W    = 11;   // square side
    localparam int unsigned CFG_IDX_W = 2;    // register index on the config port

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = CFG_IDX_W'(1);

    // Output queue geometry
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_PTR_W = 2;
    localparam int unsigned OQ_CNT_W = 3;

    // One result word
    typedef struct packed {
        logic [SIDE_W-1:0] best_side;
        logic              matrix_done;
    } t_result;

    // Zero reads as one, anything above the maximum saturates
    function automatic logic [REG_W-1:0] clamp_count(
        input logic [REG_W-1:0] v,
        input int unsigned      maxv
    );
        logic [REG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = REG_W'(1);
        end else if (32'(v) > maxv) begin
            res = REG_W'(maxv);
        end
        return res;
    endfunction

endpackage

// ===== sv/lzs_line_store.sv =====
// ----------------------------------------------------------------------------
// lzs_line_store
// Line store of per-column square sides: one write and one read port,
// read data registered (read-before-write).
// ----------------------------------------------------------------------------
module lzs_line_store #(
    parameter int unsigned DEPTH  = lzs_pkg::DEF_MAX_COLS,
    parameter int unsigned ADDR_W = 10,
    parameter int unsigned DATA_W = lzs_pkg::SIDE_W
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lzs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lzs_out_fifo
// Small result queue between the scan pipeline and the output channel.
// ----------------------------------------------------------------------------
module lzs_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  lzs_pkg::t_result                 i_data,
    input  logic                             i_pop,
    output logic                             o_valid,
    output lzs_pkg::t_result                 o_data,
    output logic [lzs_pkg::OQ_CNT_W-1:0]     o_count
);

    lzs_pkg::t_result                 r_buf [lzs_pkg::OQ_DEPTH];
    logic [lzs_pkg::OQ_PTR_W-1:0]     r_head;
    logic [lzs_pkg::OQ_PTR_W-1:0]     r_tail;
    logic [lzs_pkg::OQ_CNT_W-1:0]     r_count;
    logic                             pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_tail] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + lzs_pkg::OQ_PTR_W'(1);
            end
            if (pop_ok) begin
                r_head <= r_head + lzs_pkg::OQ_PTR_W'(1);
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + lzs_pkg::OQ_CNT_W'(1);
                2'b01:   r_count <= r_count - lzs_pkg::OQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_head];
    assign o_count = r_count;

endmodule

// ===== sv/largest_zero_square.sv =====
// ----------------------------------------------------------------------------
// largest_zero_square
// Streams a matrix row-major and reports the side of the largest all-zero
// square seen so far, using a row-by-row dynamic programme over a line store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//  input     in         i_in_valid / o_in_ready    i_element
//  output    out        o_out_valid / i_out_ready  o_best_side, o_matrix_done
//
//  One element per cycle sustained while o_in_ready holds; each element's
//  result takes the line store read, then the min/increment stage.
//  The single line store port pair sets that rate; a same-column read behind
//  a write (one-column matrices) is served by forwarding.
//  Reset is synchronous, active low; no clearing pass, the line store is only
//  read at columns written on the row before.
//  A four-word result queue keeps input accepted while output stalls.
// ----------------------------------------------------------------------------
module largest_zero_square #(
    parameter int unsigned MAX_COLS      = lzs_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS      = lzs_pkg::DEF_MAX_ROWS,
    parameter int unsigned ELEMENT_WIDTH = lzs_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [lzs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lzs_pkg::REG_W-1:0]           i_cfg_data,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ELEMENT_WIDTH-1:0]     i_element,
    // output words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lzs_pkg::SIDE_W-1:0]          o_best_side,
    output logic                                o_matrix_done
);

    localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned SW    = lzs_pkg::SIDE_W;

    // Configuration and position
    logic [lzs_pkg::REG_W-1:0] r_row_cnt;
    logic [lzs_pkg::REG_W-1:0] r_col_cnt;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          r_col;

    // Stage 1 (line store data arrives)
    logic                      r_s1_valid;
    logic                      r_s1_zero;
    logic                      r_s1_first_row;
    logic                      r_s1_first_col;
    logic                      r_s1_done;
    logic                      r_s1_fwd;
    logic [COL_W-1:0]          r_s1_col;
    logic [SW-1:0]             r_fwd_side;

    // Running values along the row
    logic [SW-1:0]             r_left;
    logic [SW-1:0]             r_diag;
    logic [SW-1:0]             r_best;

    logic                      in_acc;
    logic                      col_last;
    logic                      row_last;
    logic                      done0;
    logic [SW-1:0]             rd_data;
    logic [SW-1:0]             up;
    logic [SW-1:0]             left;
    logic [SW-1:0]             diag;
    logic [SW-1:0]             min3;
    logic [SW-1:0]             side;
    logic [SW-1:0]             best_new;
    lzs_pkg::t_result          res_in;
    lzs_pkg::t_result          res_out;
    logic [lzs_pkg::OQ_CNT_W-1:0] oq_count;
    logic [lzs_pkg::OQ_CNT_W:0]   occupancy;

    // Flow control: words in flight never exceed the queue depth
    assign occupancy  = {1'b0, oq_count} + (lzs_pkg::OQ_CNT_W + 1)'(r_s1_valid);
    assign o_in_ready = (occupancy < (lzs_pkg::OQ_CNT_W + 1)'(lzs_pkg::OQ_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;

    // Position decode for the word being accepted
    assign col_last = (32'(r_col) + 32'd1) >= 32'(r_col_cnt);
    assign row_last = (32'(r_row) + 32'd1) >= 32'(r_row_cnt);
    assign done0    = col_last && row_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= lzs_pkg::REG_W'(1);
            r_col_cnt <= lzs_pkg::REG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lzs_pkg::REG_ROW_COUNT:
                    r_row_cnt <= lzs_pkg::clamp_count(i_cfg_data, MAX_ROWS);
                lzs_pkg::REG_COLUMN_COUNT:
                    r_col_cnt <= lzs_pkg::clamp_count(i_cfg_data, MAX_COLS);
                default: ;
            endcase
        end
    end

    // Scan position; a write to the row or column count restarts the matrix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == lzs_pkg::REG_ROW_COUNT ||
                                     i_cfg_index == lzs_pkg::REG_COLUMN_COUNT)) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= done0 ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    // Stage 1 payload; forward when the word ahead writes the same column now
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_zero      <= (i_element == '0);
            r_s1_first_row <= (r_row == '0);
            r_s1_first_col <= (r_col == '0);
            r_s1_done      <= done0;
            r_s1_col       <= r_col;
            r_s1_fwd       <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_side     <= side;
        end
    end

    // Line store
    lzs_line_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W),
        .DATA_W (SW)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (side),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data)
    );

    // Neighbours, three-way minimum and increment
    always_comb begin
        up   = r_s1_first_row ? '0 : (r_s1_fwd ? r_fwd_side : rd_data);
        left = r_s1_first_col ? '0 : r_left;
        diag = r_s1_first_col ? '0 : r_diag;
        min3 = up;
        if (left < min3) begin
            min3 = left;
        end
        if (diag < min3) begin
            min3 = diag;
        end
        side     = r_s1_zero ? (min3 + SW'(1)) : '0;
        best_new = (side > r_best) ? side : r_best;
    end

    // Row state and best side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_diag <= '0;
            r_best <= '0;
        end else if (i_cfg_wr_en && (i_cfg_index == lzs_pkg::REG_ROW_COUNT ||
                                     i_cfg_index == lzs_pkg::REG_COLUMN_COUNT)) begin
            r_left <= '0;
            r_diag <= '0;
            r_best <= '0;
        end else if (r_s1_valid) begin
            r_left <= side;
            r_diag <= up;
            r_best <= r_s1_done ? '0 : best_new;
        end
    end

    // Result queue
    assign res_in.best_side   = best_new;
    assign res_in.matrix_done = r_s1_done;

    lzs_out_fifo u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res_in),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (res_out),
        .o_count (oq_count)
    );

    assign o_best_side   = res_out.best_side;
    assign o_matrix_done = res_out.matrix_done;

`ifndef SYNTHESIS
    // Queue never overflows: a word in stage 1 always has a free slot
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (oq_count < lzs_pkg::OQ_CNT_W'(lzs_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

    // The last word of a matrix leaves the position at the origin
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && done0 && !i_cfg_wr_en) |=> (r_row == '0 && r_col == '0))
        else $error("position not cleared after matrix end");

    // Forwarding only between consecutive words on the same column
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> (r_s1_col == $past(r_s1_col)))
        else $error("bad forward");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the largest zero square finder. Matrices of assorted
// shapes stream in word by word; a scoreboard keeps its own line of per-column
// square sides, works out the expected best side and end-of-matrix flag for
// every accepted word, and compares each returned word against the oldest one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned EW           = lzs_pkg::DEF_ELEMENT_WIDTH;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned EDGE_WORDS   = 120;
    localparam int unsigned RANDOM_WORDS = 640;
    localparam int unsigned CALM_WORDS   = 150;

    // Register indexes beyond the two real registers; writes there are ignored
    localparam logic [lzs_pkg::CFG_IDX_W-1:0] SPARE_INDEX_2 = lzs_pkg::CFG_IDX_W'(2);
    localparam logic [lzs_pkg::CFG_IDX_W-1:0] SPARE_INDEX_3 = lzs_pkg::CFG_IDX_W'(3);

    // Tracks the scan position and per-column square sides, predicts results
    class square_board;
        int unsigned      line_sides [lzs_pkg::DEF_MAX_COLS];
        int unsigned      left_side, diag_side, best_now, row_pos, col_pos;
        int unsigned      row_limit, col_limit;
        lzs_pkg::t_result awaited_results [$];
        int unsigned      fail_count, words_seen, results_seen, matrices_seen, peak_side;

        function new();
            row_limit     = 1;
            col_limit     = 1;
            fail_count    = 0;
            words_seen    = 0;
            results_seen  = 0;
            matrices_seen = 0;
            peak_side     = 0;
            restart_scan();
        endfunction

        function void restart_scan();
            left_side = 0;
            diag_side = 0;
            best_now  = 0;
            row_pos   = 0;
            col_pos   = 0;
        endfunction

        // Zero reads as one, anything above the ceiling saturates
        function int unsigned clamp_size(logic [lzs_pkg::REG_W-1:0] value,
                                         int unsigned ceiling);
            if (value == '0) begin
                return 1;
            end else if (int'(value) > ceiling) begin
                return ceiling;
            end
            return 32'(value);
        endfunction

        function void apply_write(logic [lzs_pkg::CFG_IDX_W-1:0] index,
                                  logic [lzs_pkg::REG_W-1:0] value);
            case (index)
                lzs_pkg::REG_ROW_COUNT: begin
                    row_limit = clamp_size(value, lzs_pkg::DEF_MAX_ROWS);
                    restart_scan();
                end
                lzs_pkg::REG_COLUMN_COUNT: begin
                    col_limit = clamp_size(value, lzs_pkg::DEF_MAX_COLS);
                    restart_scan();
                end
                default: ;
            endcase
        endfunction

        // One accepted word: new side is 1 + min(up, left, diagonal) on a zero
        function void track_element(logic [EW-1:0] value);
            int unsigned      up, left, diag, side;
            logic             last;
            lzs_pkg::t_result want;
            up   = 0;
            left = 0;
            diag = 0;
            side = 0;
            words_seen++;
            if (row_pos > 0) up = line_sides[col_pos];
            if (col_pos > 0) begin
                left = left_side;
                diag = diag_side;
            end
            if (value == '0) begin
                side = up;
                if (left < side) side = left;
                if (diag < side) side = diag;
                side = side + 1;
            end
            line_sides[col_pos] = side;
            diag_side = up;
            left_side = side;
            if (side > best_now) best_now = side;

            last = (row_pos + 1 >= row_limit) && (col_pos + 1 >= col_limit);
            want.best_side   = lzs_pkg::SIDE_W'(best_now);
            want.matrix_done = last;
            awaited_results.insert(awaited_results.size(), want);

            // advance the scan position
            if (last) begin
                matrices_seen++;
                if (best_now > peak_side) peak_side = best_now;
                restart_scan();
            end else if (col_pos + 1 >= col_limit) begin
                col_pos   = 0;
                row_pos   = row_pos + 1;
                left_side = 0;
                diag_side = 0;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_result(logic [lzs_pkg::SIDE_W-1:0] side, logic done);
            lzs_pkg::t_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                $error("result word with nothing outstanding: best_side %0d, matrix_done %0b",
                       side, done);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (side !== want.best_side) begin
                    $error("best_side: expected %0d, got %0d", want.best_side, side);
                    fail_count++;
                end
                if (done !== want.matrix_done) begin
                    $error("matrix_done: expected %0b, got %0b", want.matrix_done, done);
                    fail_count++;
                end
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            cfg_wr_en     = 1'b0;
    logic [lzs_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [lzs_pkg::REG_W-1:0]       cfg_data      = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_ready;
    logic signed [EW-1:0]            element_in    = '0;
    logic                            out_valid;
    logic                            out_ready     = 1'b0;
    logic [lzs_pkg::SIDE_W-1:0]      out_best_side;
    logic                            out_matrix_done;

    bit                              tx_gaps       = 1'b0;
    bit                              rx_stalls     = 1'b0;
    bit                              hold_request  = 1'b0;
    int unsigned                     quiet_cycles  = 0;
    square_board                     board;

    largest_zero_square dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_element     (element_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_best_side   (out_best_side),
        .o_matrix_done (out_matrix_done)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Observe register writes, accepted words and returned words
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_wr_en) board.apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready) board.track_element(element_in);
            if (out_valid && out_ready) board.check_result(out_best_side, out_matrix_done);
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Receiver: ready with random stall bursts, plus one long hold-off on request
    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_stalls && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Mostly zeros so that squares grow; the rest hit single bits or anything
    function automatic logic [EW-1:0] pick_element(input int unsigned zero_pct);
        logic [EW-1:0] value;
        if ($urandom_range(0, 99) < zero_pct) begin
            value = '0;
        end else begin
            case ($urandom_range(0, 2))
                0:       value = EW'(1) << $urandom_range(0, EW - 1);
                1:       value = ~(EW'(1) << $urandom_range(0, EW - 1));
                default: value = EW'($urandom);
            endcase
        end
        return value;
    endfunction

    task automatic write_register(input logic [lzs_pkg::CFG_IDX_W-1:0] index,
                                  input logic [lzs_pkg::REG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word, with an optional idle burst first; returns once accepted
    task automatic send_element(input logic [EW-1:0] value);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        element_in <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result word
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    initial begin
        int unsigned random_words, rows, cols, words, zero_pct;
        bit          first_phase, calm;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset shape is 1x1, so every word ends a matrix
        send_element('0);
        send_element(EW'(32'h8000_0000));
        settle();

        // 3x3 of zeros, paused half way with a spare-index write that must not restart
        write_register(lzs_pkg::REG_ROW_COUNT, lzs_pkg::REG_W'(3));
        write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(3));
        repeat (4) send_element('0);
        settle();
        write_register(SPARE_INDEX_2, lzs_pkg::REG_W'(2));
        repeat (5) send_element('0);
        settle();

        // Row count of zero reads as one; extreme values are nonzero
        write_register(lzs_pkg::REG_ROW_COUNT, '0);
        write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(4));
        send_element(EW'(32'h7FFF_FFFF));
        send_element(EW'(32'hFFFF_FFFF));
        send_element('0);
        send_element(EW'(32'h0000_0001));
        settle();

        // Restart part way through a 2x2 matrix, then a full one
        write_register(lzs_pkg::REG_ROW_COUNT, lzs_pkg::REG_W'(2));
        write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(2));
        send_element('0);
        send_element('0);
        settle();
        write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(2));
        write_register(SPARE_INDEX_3, '1);
        repeat (4) send_element('0);
        settle();

        // Widest rows, then the tallest column (counts above the maximum saturate);
        // both are scanned only in part and the next register write restarts them
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_register(lzs_pkg::REG_ROW_COUNT, lzs_pkg::REG_W'(2));
        write_register(lzs_pkg::REG_COLUMN_COUNT, '1);
        repeat (EDGE_WORDS) send_element(pick_element(97));
        settle();
        write_register(lzs_pkg::REG_ROW_COUNT, '1);
        write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(1));
        repeat (EDGE_WORDS) send_element(pick_element(90));
        settle();

        // Random shapes; the first phase holds the output off to back up the input
        random_words = 0;
        first_phase  = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            calm      = random_words + CALM_WORDS >= RANDOM_WORDS;
            tx_gaps   = !calm && $urandom_range(0, 2) != 0;
            rx_stalls = !calm && $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 7))
                0: begin
                    rows = 1;
                    cols = $urandom_range(1, 16);
                end
                1: begin
                    rows = $urandom_range(1, 16);
                    cols = 1;
                end
                2: begin
                    rows = $urandom_range(14, 24);
                    cols = rows;
                end
                default: begin
                    rows = $urandom_range(1, 12);
                    cols = $urandom_range(1, 12);
                end
            endcase
            case ($urandom_range(0, 2))
                0:       zero_pct = 60;
                1:       zero_pct = 85;
                default: zero_pct = 97;
            endcase
            words = rows * cols;
            if (words <= 100) words = words * $urandom_range(1, 3);
            if ($urandom_range(0, 5) == 0) words = $urandom_range(1, rows * cols);
            if (first_phase) begin
                rows         = 12;
                cols         = 12;
                words        = rows * cols;
                tx_gaps      = 1'b0;
                first_phase  = 1'b0;
                hold_request = 1'b1;
            end
            if (words > RANDOM_WORDS - random_words) words = RANDOM_WORDS - random_words;

            if ($urandom_range(0, 1) == 0) begin
                write_register(lzs_pkg::REG_ROW_COUNT, lzs_pkg::REG_W'(rows));
                write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(cols));
            end else begin
                write_register(lzs_pkg::REG_COLUMN_COUNT, lzs_pkg::REG_W'(cols));
                write_register(lzs_pkg::REG_ROW_COUNT, lzs_pkg::REG_W'(rows));
            end
            if ($urandom_range(0, 9) == 0) begin
                write_register($urandom_range(0, 1) ? SPARE_INDEX_2 : SPARE_INDEX_3,
                               lzs_pkg::REG_W'($urandom));
            end

            repeat (words) send_element(pick_element(zero_pct));
            random_words += words;
            settle();
        end

        // Let anything stray surface before the verdict
        repeat (10) @(posedge clk);
        $display("Streamed %0d words and checked %0d results over %0d finished matrices;",
                 board.words_seen, board.results_seen, board.matrices_seen);
        $display("shapes from 1x1 to 24x24, part scans of 2x%0d and %0dx1, largest side %0d.",
                 lzs_pkg::DEF_MAX_COLS, lzs_pkg::DEF_MAX_ROWS, board.peak_side);
        if (board.fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lzs_pkg.sv
sv/lzs_line_store.sv
sv/lzs_out_fifo.sv
sv/largest_zero_square.sv
dv/testbench.sv
